FILE: rtl/core/lcsb_pkg.sv
// ============================================================================
// lcsb_pkg - shared types and constants for the link connect supervisor
// Holds the event and status codes, the configuration record, the record
// passed between pipeline stages and the backoff length function.
// ============================================================================
package lcsb_pkg;

    // Configuration reset values
    localparam logic [31:0] TIMEOUT_RST = 32'd15000;
    localparam logic [15:0] BASE_RST    = 16'd10000;
    localparam logic [3:0]  SHIFT_RST   = 4'd6;

    // Register indexes on the APB port (byte address = 4 * index)
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_BASE    = 2'd1;
    localparam logic [1:0] REG_SHIFT   = 2'd2;

    // Failure counter saturation
    localparam logic [7:0] FAIL_MAX = 8'd255;

    // Round-up term for milliseconds to seconds
    localparam logic [31:0] ROUND_UP_MS = 32'd999;

    // n / 1000 = ((n >> 3) * DIV125_MAGIC) >> DIV125_SHIFT, exact for n < 2^32
    localparam logic [29:0] DIV125_MAGIC = 30'd549755814;
    localparam int          DIV125_SHIFT = 36;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONNECTING,
        ST_CONNECTED,
        ST_FAILED
    } link_state_t;

    typedef enum logic [1:0] {
        FN_POLL,
        FN_CONNECT,
        FN_DISCONNECT,
        FN_RESET_BACKOFF
    } func_t;

    typedef enum logic [1:0] {
        RS_OTHER,
        RS_CONNECTED,
        RS_SSID_GONE,
        RS_CONNECT_FAILED
    } radio_status_t;

    typedef enum logic [3:0] {
        ERR_NONE,
        ERR_SSID_MISSING,
        ERR_BUSY,
        ERR_RETRY_WAIT,
        ERR_MODE_FAIL,
        ERR_SSID_NOT_FOUND,
        ERR_AUTH,
        ERR_TIMEOUT,
        ERR_LINK_LOST
    } err_t;

    typedef struct packed {
        logic [31:0] timeout_ms;
        logic [15:0] base_ms;
        logic [3:0]  max_shift;
    } cfg_t;

    typedef struct packed {
        func_t         func;
        logic [31:0]   now_ms;
        radio_status_t link_status;
        logic          ssid_present;
        logic          mode_ok;
    } item_t;

    // Event results after the state update, before the seconds divide
    typedef struct packed {
        link_state_t link_state;
        logic        accepted;
        err_t        error_code;
        logic [28:0] retry_num;     // (wait_ms + 999) >> 3, zero if no refusal
        logic [7:0]  fail_count;
        logic [31:0] last_fail_ms;
        logic [31:0] now_ms;
        logic        is_connected;
        logic        owns_radio;
    } stage_t;

    // Backoff length: base << min(fails - 1, max_shift)
    function automatic logic [30:0] backoff_len(
        input logic [7:0]  fails,
        input logic [15:0] base,
        input logic [3:0]  max_shift
    );
        logic [7:0] sh;
        logic [3:0] amt;
        sh  = (fails != 8'd0) ? (fails - 8'd1) : 8'd0;
        amt = (sh > {4'd0, max_shift}) ? max_shift : sh[3:0];
        return {15'd0, base} << amt;
    endfunction

endpackage

FILE: rtl/core/lcsb_ctrl.sv
// ============================================================================
// lcsb_ctrl - supervisor state and event decision
// Holds the link state, attempt start, last failure time, failure count and
// last error; decides one event from the input register per advance.
// ============================================================================
module lcsb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  lcsb_pkg::item_t  item,
    input  lcsb_pkg::cfg_t   cfg,
    output lcsb_pkg::stage_t res
);

    lcsb_pkg::link_state_t state_reg, state_next;
    logic [31:0]           start_reg, start_next;
    logic [31:0]           last_fail_reg, last_fail_next;
    logic [7:0]            fails_reg, fails_next;
    lcsb_pkg::err_t        err_reg, err_next;

    logic [31:0] el_start;
    logic [31:0] el_fail;
    logic [30:0] bo;
    logic [31:0] wait_num;
    logic        waiting;
    logic        do_fail;
    lcsb_pkg::err_t fail_code;
    logic        accepted;
    logic [28:0] retry_num;

    // Elapsed times and current backoff
    assign el_start = item.now_ms - start_reg;
    assign el_fail  = item.now_ms - last_fail_reg;
    assign bo       = lcsb_pkg::backoff_len(fails_reg, cfg.base_ms, cfg.max_shift);
    assign waiting  = (fails_reg != 8'd0) && (el_fail < {1'b0, bo});
    // el_fail < bo here, so it fits 31 bits
    assign wait_num = {1'b0, bo - el_fail[30:0]} + lcsb_pkg::ROUND_UP_MS;

    // Event decision
    always_comb begin
        state_next     = state_reg;
        start_next     = start_reg;
        last_fail_next = last_fail_reg;
        fails_next     = fails_reg;
        err_next       = err_reg;
        do_fail        = 1'b0;
        fail_code      = lcsb_pkg::ERR_NONE;
        accepted       = 1'b0;
        retry_num      = '0;

        case (item.func)
            lcsb_pkg::FN_POLL: begin
                if (state_reg == lcsb_pkg::ST_CONNECTING) begin
                    if (item.link_status == lcsb_pkg::RS_CONNECTED) begin
                        state_next = lcsb_pkg::ST_CONNECTED;
                        fails_next = 8'd0;
                        err_next   = lcsb_pkg::ERR_NONE;
                    end else if (item.link_status == lcsb_pkg::RS_SSID_GONE) begin
                        do_fail   = 1'b1;
                        fail_code = lcsb_pkg::ERR_SSID_NOT_FOUND;
                    end else if (item.link_status == lcsb_pkg::RS_CONNECT_FAILED) begin
                        do_fail   = 1'b1;
                        fail_code = lcsb_pkg::ERR_AUTH;
                    end else if (el_start > cfg.timeout_ms) begin
                        do_fail   = 1'b1;
                        fail_code = lcsb_pkg::ERR_TIMEOUT;
                    end
                end else if (state_reg == lcsb_pkg::ST_CONNECTED) begin
                    if (item.link_status != lcsb_pkg::RS_CONNECTED) begin
                        do_fail   = 1'b1;
                        fail_code = lcsb_pkg::ERR_LINK_LOST;
                    end
                end
            end
            lcsb_pkg::FN_CONNECT: begin
                if (!item.ssid_present) begin
                    // missing name wins even when busy; count untouched
                    state_next = lcsb_pkg::ST_FAILED;
                    err_next   = lcsb_pkg::ERR_SSID_MISSING;
                end else if (state_reg == lcsb_pkg::ST_CONNECTING ||
                             state_reg == lcsb_pkg::ST_CONNECTED) begin
                    err_next = lcsb_pkg::ERR_BUSY;
                end else if (waiting) begin
                    state_next = lcsb_pkg::ST_FAILED;
                    err_next   = lcsb_pkg::ERR_RETRY_WAIT;
                    retry_num  = wait_num[31:3];
                end else if (!item.mode_ok) begin
                    do_fail   = 1'b1;
                    fail_code = lcsb_pkg::ERR_MODE_FAIL;
                end else begin
                    state_next = lcsb_pkg::ST_CONNECTING;
                    start_next = item.now_ms;
                    err_next   = lcsb_pkg::ERR_NONE;
                    accepted   = 1'b1;
                end
            end
            lcsb_pkg::FN_DISCONNECT: begin
                state_next = lcsb_pkg::ST_IDLE;
            end
            lcsb_pkg::FN_RESET_BACKOFF: begin
                fails_next     = 8'd0;
                last_fail_next = 32'd0;
                err_next       = lcsb_pkg::ERR_NONE;
                if (state_reg == lcsb_pkg::ST_FAILED) begin
                    state_next = lcsb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase

        // Common failure bookkeeping
        if (do_fail) begin
            state_next     = lcsb_pkg::ST_FAILED;
            last_fail_next = item.now_ms;
            err_next       = fail_code;
            if (fails_reg != lcsb_pkg::FAIL_MAX) begin
                fails_next = fails_reg + 8'd1;
            end
        end
    end

    // Stage result
    always_comb begin
        res.link_state   = state_next;
        res.accepted     = accepted;
        res.error_code   = err_next;
        res.retry_num    = retry_num;
        res.fail_count   = fails_next;
        res.last_fail_ms = last_fail_next;
        res.now_ms       = item.now_ms;
        res.is_connected = (state_next == lcsb_pkg::ST_CONNECTED) &&
                           (item.link_status == lcsb_pkg::RS_CONNECTED);
        res.owns_radio   = (state_next != lcsb_pkg::ST_IDLE);
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcsb_pkg::ST_IDLE;
            start_reg     <= 32'd0;
            last_fail_reg <= 32'd0;
            fails_reg     <= 8'd0;
            err_reg       <= lcsb_pkg::ERR_NONE;
        end else if (advance) begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            last_fail_reg <= last_fail_next;
            fails_reg     <= fails_next;
            err_reg       <= err_next;
        end
    end

endmodule

FILE: rtl/core/lcsb_finish.sv
// ============================================================================
// lcsb_finish - seconds divide and remaining backoff
// Turns the rounded wait into whole seconds by a reciprocal multiply and
// computes the backoff still left from the updated failure state.
// ============================================================================
module lcsb_finish (
    input  lcsb_pkg::stage_t mid,
    input  lcsb_pkg::cfg_t   cfg,
    output logic [21:0]      retry_seconds,
    output logic [30:0]      backoff_left_ms
);

    logic [58:0] prod;
    logic [31:0] el;
    logic [30:0] bo;

    // Divide by 1000: numerator already shifted right by 3, divide by 125
    assign prod = 59'(mid.retry_num) * 59'(lcsb_pkg::DIV125_MAGIC);
    assign retry_seconds = prod[lcsb_pkg::DIV125_SHIFT +: 22];

    // Remaining backoff; a failure time of zero means no failure
    assign el = mid.now_ms - mid.last_fail_ms;
    assign bo = lcsb_pkg::backoff_len(mid.fail_count, cfg.base_ms, cfg.max_shift);

    always_comb begin
        backoff_left_ms = 31'd0;
        if (mid.fail_count != 8'd0 && mid.last_fail_ms != 32'd0 &&
            el < {1'b0, bo}) begin
            backoff_left_ms = bo - el[30:0];
        end
    end

endmodule

FILE: rtl/core/link_connect_supervisor_backoff.sv
// ============================================================================
// link_connect_supervisor_backoff - radio link connect supervisor
// Supervises connect attempts with exponential retry backoff; one result
// word per event word.
// ============================================================================
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tuser func, s_tdata event fields
//  m_        out        m_tvalid/m_tready  m_tdata result fields
//  apb       in/out     psel/penable       3 config registers at 0x0/0x4/0x8
//
// One event word per cycle sustained while m_tready is high; each word passes
// the input register, decision stage and divide-by-1000 multiply stage into
// the output register. Each stage holds its word and stalls only when the
// stage after it is full and not draining, so bubbles are absorbed. Reset
// (aresetn low, synchronous) empties the pipeline, clears the supervisor
// state and reloads the configuration defaults.
//
module link_connect_supervisor_backoff (
    input  logic        aclk,
    input  logic        aresetn,
    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // now_ms[31:0], link_status[33:32],
                                   // ssid_present[34], mode_ok[35], zero[39:36]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // link_state[1:0], accepted[2],
                                   // error_code[6:3], retry_seconds[28:7],
                                   // backoff_left_ms[59:29], fail_count[67:60],
                                   // is_connected[68], owns_radio[69],
                                   // zero[71:70]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lcsb_pkg::cfg_t   cfg_reg;
    lcsb_pkg::item_t  in_reg;
    logic             in_valid_reg;
    lcsb_pkg::stage_t mid_reg;
    logic             mid_valid_reg;
    logic [71:0]      out_reg;
    logic             out_valid_reg;

    lcsb_pkg::stage_t ctrl_res;
    logic [21:0]      retry_seconds;
    logic [30:0]      backoff_left_ms;
    logic             rdy_out;
    logic             rdy_mid;
    logic             rdy_in;
    logic             cfg_wr;

    // Stage ready chain
    assign rdy_out  = !out_valid_reg || m_tready;
    assign rdy_mid  = !mid_valid_reg || rdy_out;
    assign rdy_in   = !in_valid_reg || rdy_mid;
    assign s_tready = rdy_in;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms <= lcsb_pkg::TIMEOUT_RST;
            cfg_reg.base_ms    <= lcsb_pkg::BASE_RST;
            cfg_reg.max_shift  <= lcsb_pkg::SHIFT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                lcsb_pkg::REG_TIMEOUT: cfg_reg.timeout_ms <= pwdata;
                lcsb_pkg::REG_BASE:    cfg_reg.base_ms    <= pwdata[15:0];
                lcsb_pkg::REG_SHIFT:   cfg_reg.max_shift  <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lcsb_pkg::REG_TIMEOUT: prdata = cfg_reg.timeout_ms;
            lcsb_pkg::REG_BASE:    prdata = {16'd0, cfg_reg.base_ms};
            lcsb_pkg::REG_SHIFT:   prdata = {28'd0, cfg_reg.max_shift};
            default:               prdata = 32'd0;
        endcase
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (rdy_in) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy_in) begin
            in_reg.func         <= lcsb_pkg::func_t'(s_tuser);
            in_reg.now_ms       <= s_tdata[31:0];
            in_reg.link_status  <= lcsb_pkg::radio_status_t'(s_tdata[33:32]);
            in_reg.ssid_present <= s_tdata[34];
            in_reg.mode_ok      <= s_tdata[35];
        end
    end

    // Decision stage; state commits as the word moves on
    lcsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (in_valid_reg && rdy_mid),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .res     (ctrl_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (rdy_mid) begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && rdy_mid) begin
            mid_reg <= ctrl_res;
        end
    end

    // Divide and remaining backoff stage
    lcsb_finish u_finish (
        .mid             (mid_reg),
        .cfg             (cfg_reg),
        .retry_seconds   (retry_seconds),
        .backoff_left_ms (backoff_left_ms)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rdy_out) begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_valid_reg && rdy_out) begin
            out_reg <= {2'b00,
                        mid_reg.owns_radio,
                        mid_reg.is_connected,
                        mid_reg.fail_count,
                        backoff_left_ms,
                        retry_seconds,
                        mid_reg.error_code,
                        mid_reg.accepted,
                        mid_reg.link_state};
        end
    end

endmodule

FILE: tb/sv/link_connect_supervisor_backoff_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_connect_supervisor_backoff_tb - self-checking bench for the supervisor
// Feeds event words on the s_ stream and checks every m_ result word against
// a cycle-free predictor of the connect/backoff state machine. It starts with
// a directed walk through the special cases and a failure-count saturation
// burst. It then runs random phases under several register settings, with
// random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module link_connect_supervisor_backoff_tb;

    // Result word layout, lowest field last
    typedef struct packed {
        logic                  owns_radio;
        logic                  is_connected;
        logic [7:0]            fails;
        logic [30:0]           left_ms;
        logic [21:0]           retry_s;
        lcsb_pkg::err_t        error_code;
        logic                  accepted;
        lcsb_pkg::link_state_t link_state;
    } outcome_t;

    // Predicts the result of each accepted event and checks the results
    class supervisor_scoreboard;
        logic [31:0]           timeout_ms;
        logic [15:0]           base_ms;
        logic [3:0]            max_shift;
        lcsb_pkg::link_state_t st;
        logic [31:0]           start_ms;
        logic [31:0]           fail_ms;
        logic [7:0]            fails;
        lcsb_pkg::err_t        err;
        outcome_t              pending_outcomes[$];
        int                    faults;

        function new();
            timeout_ms = lcsb_pkg::TIMEOUT_RST;
            base_ms    = lcsb_pkg::BASE_RST;
            max_shift  = lcsb_pkg::SHIFT_RST;
            st         = lcsb_pkg::ST_IDLE;
            start_ms   = '0;
            fail_ms    = '0;
            fails      = '0;
            err        = lcsb_pkg::ERR_NONE;
            faults     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                lcsb_pkg::REG_TIMEOUT: timeout_ms = val;
                lcsb_pkg::REG_BASE:    base_ms    = val[15:0];
                lcsb_pkg::REG_SHIFT:   max_shift  = val[3:0];
                default: ;
            endcase
        endfunction

        // base << min(fails - 1, max_shift)
        function logic [31:0] wait_len();
            logic [7:0] sh;
            sh = (fails != 8'd0) ? fails - 8'd1 : 8'd0;
            if (sh > {4'd0, max_shift})
                sh = {4'd0, max_shift};
            return {16'd0, base_ms} << sh[3:0];
        endfunction

        function void log_failure(logic [31:0] now, lcsb_pkg::err_t code);
            st      = lcsb_pkg::ST_FAILED;
            fail_ms = now;
            if (fails != lcsb_pkg::FAIL_MAX)
                fails = fails + 8'd1;
            err     = code;
        endfunction

        function outcome_t predict_event(lcsb_pkg::item_t ev);
            outcome_t    o;
            logic [31:0] since;
            logic [31:0] bo;
            o = '0;
            case (ev.func)
                lcsb_pkg::FN_POLL: begin
                    if (st == lcsb_pkg::ST_CONNECTING) begin
                        since = ev.now_ms - start_ms;
                        if (ev.link_status == lcsb_pkg::RS_CONNECTED) begin
                            st    = lcsb_pkg::ST_CONNECTED;
                            fails = '0;
                            err   = lcsb_pkg::ERR_NONE;
                        end else if (ev.link_status == lcsb_pkg::RS_SSID_GONE) begin
                            log_failure(ev.now_ms, lcsb_pkg::ERR_SSID_NOT_FOUND);
                        end else if (ev.link_status == lcsb_pkg::RS_CONNECT_FAILED) begin
                            log_failure(ev.now_ms, lcsb_pkg::ERR_AUTH);
                        end else if (since > timeout_ms) begin
                            log_failure(ev.now_ms, lcsb_pkg::ERR_TIMEOUT);
                        end
                    end else if (st == lcsb_pkg::ST_CONNECTED &&
                                 ev.link_status != lcsb_pkg::RS_CONNECTED) begin
                        log_failure(ev.now_ms, lcsb_pkg::ERR_LINK_LOST);
                    end
                end
                lcsb_pkg::FN_CONNECT: begin
                    if (!ev.ssid_present) begin
                        // name check comes first, even while busy
                        st  = lcsb_pkg::ST_FAILED;
                        err = lcsb_pkg::ERR_SSID_MISSING;
                    end else if (st == lcsb_pkg::ST_CONNECTING ||
                                 st == lcsb_pkg::ST_CONNECTED) begin
                        err = lcsb_pkg::ERR_BUSY;
                    end else begin
                        // backoff applies on count alone, a zero fail time included
                        since = ev.now_ms - fail_ms;
                        bo    = wait_len();
                        if (fails != 8'd0 && since < bo) begin
                            st        = lcsb_pkg::ST_FAILED;
                            err       = lcsb_pkg::ERR_RETRY_WAIT;
                            o.retry_s = 22'((bo - since + 32'd999) / 32'd1000);
                        end else begin
                            err = lcsb_pkg::ERR_NONE;
                            if (!ev.mode_ok) begin
                                log_failure(ev.now_ms, lcsb_pkg::ERR_MODE_FAIL);
                            end else begin
                                st         = lcsb_pkg::ST_CONNECTING;
                                start_ms   = ev.now_ms;
                                o.accepted = 1'b1;
                            end
                        end
                    end
                end
                lcsb_pkg::FN_DISCONNECT: st = lcsb_pkg::ST_IDLE;
                default: begin
                    fails   = '0;
                    fail_ms = '0;
                    if (st == lcsb_pkg::ST_FAILED)
                        st = lcsb_pkg::ST_IDLE;
                    err     = lcsb_pkg::ERR_NONE;
                end
            endcase

            // remaining backoff; a fail time of zero means no failure
            if (fails != 8'd0 && fail_ms != 32'd0) begin
                since = ev.now_ms - fail_ms;
                bo    = wait_len();
                if (since < bo)
                    o.left_ms = 31'(bo - since);
            end
            o.link_state   = st;
            o.error_code   = err;
            o.fails        = fails;
            o.is_connected = (st == lcsb_pkg::ST_CONNECTED &&
                              ev.link_status == lcsb_pkg::RS_CONNECTED);
            o.owns_radio   = (st != lcsb_pkg::ST_IDLE);
            return o;
        endfunction

        function void note_event(lcsb_pkg::item_t ev);
            pending_outcomes.push_back(predict_event(ev));
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function void match_field(string tag, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch %0s: expected %0d, got %0d", tag, want, got);
            end
        endfunction

        function void check_result(logic [71:0] word);
            outcome_t want;
            outcome_t got;
            got = word[69:0];
            if (pending_outcomes.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result word %h", word);
                return;
            end
            want = pending_outcomes.pop_front();
            match_field("link_state", 32'(want.link_state), 32'(got.link_state));
            match_field("accepted", 32'(want.accepted), 32'(got.accepted));
            match_field("error_code", 32'(want.error_code), 32'(got.error_code));
            match_field("retry_seconds", 32'(want.retry_s), 32'(got.retry_s));
            match_field("backoff_left_ms", 32'(want.left_ms), 32'(got.left_ms));
            match_field("fail_count", 32'(want.fails), 32'(got.fails));
            match_field("is_connected", 32'(want.is_connected), 32'(got.is_connected));
            match_field("owns_radio", 32'(want.owns_radio), 32'(got.owns_radio));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // now_ms[31:0], link_status[33:32], ssid_present[34],
                            // mode_ok[35], zero[39:36]
    logic [1:0]  s_tuser;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // link_state[1:0], accepted[2], error_code[6:3],
                            // retry_seconds[28:7], backoff_left_ms[59:29],
                            // fail_count[67:60], is_connected[68], owns_radio[69]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    supervisor_scoreboard sb;
    logic        no_idle;
    logic [31:0] clock_ms;

    link_connect_supervisor_backoff i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: check each accepted word, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= no_idle || ($urandom_range(99) >= 9);
    end

    // APB write: setup cycle, then access until pready
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_config(input logic [31:0] tmo, input logic [15:0] base,
                               input logic [3:0] shift);
        write_reg(lcsb_pkg::REG_TIMEOUT, tmo);
        write_reg(lcsb_pkg::REG_BASE, {16'd0, base});
        write_reg(lcsb_pkg::REG_SHIFT, {28'd0, shift});
    endtask

    // One event word, with an optional random gap ahead of it
    task automatic send_event(input lcsb_pkg::item_t ev);
        while (!no_idle && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, ev.mode_ok, ev.ssid_present, ev.link_status, ev.now_ms};
        s_tuser  <= ev.func;
        do @(posedge aclk); while (!s_tready);
        sb.note_event(ev);
    endtask

    // Stop sending and let every pending result come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic lcsb_pkg::item_t mk(lcsb_pkg::func_t f, logic [31:0] now,
                                           lcsb_pkg::radio_status_t rs,
                                           logic ssid, logic mode);
        lcsb_pkg::item_t ev;
        ev.func         = f;
        ev.now_ms       = now;
        ev.link_status  = rs;
        ev.ssid_present = ssid;
        ev.mode_ok      = mode;
        return ev;
    endfunction

    // Mostly short time steps so attempts and backoffs play out, a few wraps
    function automatic lcsb_pkg::item_t random_event();
        int unsigned             r;
        lcsb_pkg::func_t         f;
        lcsb_pkg::radio_status_t rs;
        r = $urandom_range(19);
        if (r < 10)      clock_ms = clock_ms + $urandom_range(300);
        else if (r < 15) clock_ms = clock_ms + $urandom_range(30000);
        else if (r < 18) clock_ms = clock_ms + $urandom_range(32'h40_0000);
        else             clock_ms = clock_ms + $urandom;
        r = $urandom_range(99);
        if (r < 42)      f = lcsb_pkg::FN_POLL;
        else if (r < 72) f = lcsb_pkg::FN_CONNECT;
        else if (r < 84) f = lcsb_pkg::FN_DISCONNECT;
        else             f = lcsb_pkg::FN_RESET_BACKOFF;
        r = $urandom_range(9);
        if (r < 4)       rs = lcsb_pkg::RS_OTHER;
        else if (r < 7)  rs = lcsb_pkg::RS_CONNECTED;
        else if (r < 8)  rs = lcsb_pkg::RS_SSID_GONE;
        else if (r < 9)  rs = lcsb_pkg::RS_CONNECT_FAILED;
        else             rs = lcsb_pkg::radio_status_t'($urandom_range(3));
        return mk(f, clock_ms, rs, $urandom_range(99) < 92, $urandom_range(99) < 88);
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_event(random_event());
        wait_drain();
    endtask

    initial begin
        #400_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = lcsb_pkg::FN_POLL;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        no_idle  = 1'b0;
        clock_ms = 32'd0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk at reset settings
        send_event(mk(lcsb_pkg::FN_POLL, 32'd0, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // ignored when idle
        send_event(mk(lcsb_pkg::FN_DISCONNECT, 32'd5, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // name missing
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd10, lcsb_pkg::RS_OTHER, 1'b0, 1'b1));
        send_event(mk(lcsb_pkg::FN_RESET_BACKOFF, 32'd20, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // mode fail at time 0
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd0, lcsb_pkg::RS_OTHER, 1'b1, 1'b0));
        // backoff despite zero time
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd100, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // backoff just over
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd10000, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // busy
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd10001, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // name missing while busy
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd10002, lcsb_pkg::RS_OTHER, 1'b0, 1'b1));
        send_event(mk(lcsb_pkg::FN_RESET_BACKOFF, 32'd10003, lcsb_pkg::RS_OTHER,
                      1'b1, 1'b1));
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd10004, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // elapsed equals timeout
        send_event(mk(lcsb_pkg::FN_POLL, 32'd25004, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // timeout
        send_event(mk(lcsb_pkg::FN_POLL, 32'd25005, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // retry wait
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd25006, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd35005, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // ssid not found
        send_event(mk(lcsb_pkg::FN_POLL, 32'd35006, lcsb_pkg::RS_SSID_GONE, 1'b1, 1'b1));
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd55006, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // auth
        send_event(mk(lcsb_pkg::FN_POLL, 32'd55007, lcsb_pkg::RS_CONNECT_FAILED,
                      1'b1, 1'b1));
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd95007, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // connected, count cleared
        send_event(mk(lcsb_pkg::FN_POLL, 32'd95008, lcsb_pkg::RS_CONNECTED, 1'b1, 1'b1));
        send_event(mk(lcsb_pkg::FN_POLL, 32'hFFFF_FFFF, lcsb_pkg::RS_CONNECTED,
                      1'b1, 1'b1));
        // link lost
        send_event(mk(lcsb_pkg::FN_POLL, 32'hFFFF_FFFF, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // error and count kept
        send_event(mk(lcsb_pkg::FN_DISCONNECT, 32'd2, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        // wait across the wrap
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd5, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        send_event(mk(lcsb_pkg::FN_RESET_BACKOFF, 32'd6, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        wait_drain();

        // Failure count saturation with a 1 ms backoff
        load_config(32'd15000, 16'd1, 4'd0);
        for (int i = 0; i < 260; i++)
            send_event(mk(lcsb_pkg::FN_CONNECT, 32'd1000 + 32'(2 * i),
                          lcsb_pkg::RS_OTHER, 1'b1, 1'b0));
        wait_drain();

        // Longest possible backoff right after the last failure
        load_config(32'd15000, 16'hFFFF, 4'd15);
        send_event(mk(lcsb_pkg::FN_CONNECT, 32'd1519, lcsb_pkg::RS_OTHER, 1'b1, 1'b1));
        send_event(mk(lcsb_pkg::FN_POLL, 32'd1520, lcsb_pkg::RS_CONNECTED, 1'b1, 1'b1));
        send_event(mk(lcsb_pkg::FN_RESET_BACKOFF, 32'd1521, lcsb_pkg::RS_OTHER,
                      1'b1, 1'b1));
        wait_drain();

        // Random phases under several settings
        clock_ms = $urandom;
        load_config(lcsb_pkg::TIMEOUT_RST, lcsb_pkg::BASE_RST, lcsb_pkg::SHIFT_RST);
        random_phase(32);

        no_idle = 1'b1;
        load_config(32'd0, 16'd1, 4'd0);
        random_phase(32);
        no_idle = 1'b0;

        load_config(32'hFFFF_FFFF, 16'hFFFF, 4'd15);
        random_phase(32);

        load_config($urandom_range(500, 5000), 16'($urandom_range(1, 3000)),
                    4'($urandom_range(15)));
        random_phase(32);

        // zero base: no backoff at all
        load_config(32'h8000_0000 | $urandom_range(20000), 16'd0, 4'($urandom_range(15)));
        random_phase(32);

        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: link_connect_supervisor_backoff.f
rtl/core/lcsb_pkg.sv
rtl/core/lcsb_ctrl.sv
rtl/core/lcsb_finish.sv
rtl/core/link_connect_supervisor_backoff.sv
tb/sv/link_connect_supervisor_backoff_tb.sv
